// ===== rtl/ple_pkg.sv =====
// Shared constants, codes and types for the positional list engine.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package ple_pkg;

  // List geometry.
  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatW    = 3;
  localparam int unsigned FidxW    = 4;

  // Request codes.
  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TRAVERSE = 2'd2,
    ACT_SEARCH   = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  // One result beat.
  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  value;
    logic                     valid;
    logic [FidxW-1:0]         index;
    logic [CntW-1:0]          count;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Top level of the positional list engine: request sequencer, compare and
// index unit, result register. Depends on ple_pkg and ple_store.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+--------------------------
//   request  | action_i, item_value_i, position_i        | start & !busy
//   result   | status_o, element_value_o, element_valid_o,| result_valid_o, one cycle
//            | found_index_o, entry_count_o, last_result_o|
//
// Insert at the end, delete of the tail entry, traverse or search of an empty
// list, and every request that is refused move no stored entry and give their
// beat in the next cycle. Each entry that is moved, compared or emitted takes a
// read state, then a use state (SRead, then SExec), set by the single read port
// of the list memory with its registered data; an insert that shifts ends with
// a state that writes the new value (SPut). Reset clears the count and the
// sequencer; the list memory needs no clearing. The receiver cannot stall:
// each result beat is shown for exactly one cycle.
`default_nettype none

module positional_list_engine (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           action_i,
  input  wire logic signed [ple_pkg::DataW-1:0]     item_value_i,
  input  wire logic [ple_pkg::PosW-1:0]             position_i,
  output logic                                      result_valid_o,
  output logic [ple_pkg::StatW-1:0]                 status_o,
  output logic signed [ple_pkg::DataW-1:0]          element_value_o,
  output logic                                      element_valid_o,
  output logic [ple_pkg::FidxW-1:0]                 found_index_o,
  output logic [ple_pkg::CntW-1:0]                  entry_count_o,
  output logic                                      last_result_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SExec = 2'd2;
  localparam logic [1:0] SPut  = 2'd3;

  localparam logic [ple_pkg::CntW-1:0] CapCnt = ple_pkg::CntW'(ple_pkg::Capacity);
  localparam logic [ple_pkg::CntW-1:0] OneCnt = ple_pkg::CntW'(1);

  logic [1:0]                         state_q, state_d;
  logic [ple_pkg::CntW-1:0]           count_q, count_d;
  logic [ple_pkg::IdxW-1:0]           idx_q, idx_d;
  ple_pkg::action_e                   act_q, act_d;
  logic signed [ple_pkg::DataW-1:0]   val_q, val_d;
  logic [ple_pkg::IdxW-1:0]           pos_q, pos_d;
  ple_pkg::result_t                   res_q, res_d;
  logic                               res_vld_q, res_vld_d;

  logic                               rd_en;
  logic                               wr_en;
  logic [ple_pkg::IdxW-1:0]           wr_addr;
  logic signed [ple_pkg::DataW-1:0]   wr_data;
  logic signed [ple_pkg::DataW-1:0]   rd_data;
  logic [ple_pkg::CntW-1:0]           idx_plus1;
  logic                               at_last;
  logic [ple_pkg::IdxW-1:0]           pos_idx;

  ple_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // Shared index unit: next index and end-of-list test.
  assign idx_plus1 = ple_pkg::CntW'(idx_q) + OneCnt;
  assign at_last   = (idx_plus1 == count_q);
  assign pos_idx   = pos_q;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    act_d     = act_q;
    val_d     = val_q;
    pos_d     = pos_q;
    res_d     = '0;
    res_vld_d = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = rd_data;
    res_d.last  = 1'b1;
    res_d.count = count_q;

    unique case (state_q)
      SIdle: begin
        if (start) begin
          act_d = ple_pkg::action_e'(action_i);
          val_d = item_value_i;
          pos_d = position_i[ple_pkg::IdxW-1:0];
          unique case (ple_pkg::action_e'(action_i))
            ple_pkg::ACT_INSERT: begin
              if (count_q >= CapCnt) begin
                res_d.status = ple_pkg::ST_FULL;
                res_vld_d    = 1'b1;
              end else if (ple_pkg::CntW'(position_i) > count_q) begin
                res_d.status = ple_pkg::ST_BADPOS;
                res_vld_d    = 1'b1;
              end else if (ple_pkg::CntW'(position_i) == count_q) begin
                // Append: no entries move.
                wr_en        = 1'b1;
                wr_addr      = position_i[ple_pkg::IdxW-1:0];
                wr_data      = item_value_i;
                count_d      = count_q + OneCnt;
                res_d.status = ple_pkg::ST_OK;
                res_d.count  = count_q + OneCnt;
                res_vld_d    = 1'b1;
              end else begin
                idx_d   = ple_pkg::IdxW'(count_q - OneCnt);
                state_d = SRead;
              end
            end
            ple_pkg::ACT_DELETE: begin
              if (count_q == '0) begin
                res_d.status = ple_pkg::ST_EMPTY;
                res_vld_d    = 1'b1;
              end else if (ple_pkg::CntW'(position_i) >= count_q) begin
                res_d.status = ple_pkg::ST_BADPOS;
                res_vld_d    = 1'b1;
              end else if (ple_pkg::CntW'(position_i) + OneCnt == count_q) begin
                // Removing the tail entry moves nothing.
                count_d      = count_q - OneCnt;
                res_d.status = ple_pkg::ST_OK;
                res_d.count  = count_q - OneCnt;
                res_vld_d    = 1'b1;
              end else begin
                idx_d   = position_i[ple_pkg::IdxW-1:0] + ple_pkg::IdxW'(1);
                state_d = SRead;
              end
            end
            ple_pkg::ACT_TRAVERSE: begin
              if (count_q == '0) begin
                res_d.status = ple_pkg::ST_OK;
                res_vld_d    = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = SRead;
              end
            end
            ple_pkg::ACT_SEARCH: begin
              if (count_q == '0) begin
                res_d.status = ple_pkg::ST_MISSING;
                res_vld_d    = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = SRead;
              end
            end
            default: ;
          endcase
        end
      end

      SRead: begin
        rd_en   = 1'b1;
        state_d = SExec;
      end

      SExec: begin
        unique case (act_q)
          ple_pkg::ACT_INSERT: begin
            // Move one entry up, walking down toward the insert position.
            wr_en   = 1'b1;
            wr_addr = idx_q + ple_pkg::IdxW'(1);
            if (idx_q == pos_idx) begin
              state_d = SPut;
            end else begin
              idx_d   = idx_q - ple_pkg::IdxW'(1);
              state_d = SRead;
            end
          end
          ple_pkg::ACT_DELETE: begin
            // Move one entry down, walking up toward the tail.
            wr_en   = 1'b1;
            wr_addr = idx_q - ple_pkg::IdxW'(1);
            if (at_last) begin
              count_d      = count_q - OneCnt;
              res_d.status = ple_pkg::ST_OK;
              res_d.count  = count_q - OneCnt;
              res_vld_d    = 1'b1;
              state_d      = SIdle;
            end else begin
              idx_d   = idx_plus1[ple_pkg::IdxW-1:0];
              state_d = SRead;
            end
          end
          ple_pkg::ACT_TRAVERSE: begin
            res_d.status = ple_pkg::ST_OK;
            res_d.value  = rd_data;
            res_d.valid  = 1'b1;
            res_d.last   = at_last;
            res_vld_d    = 1'b1;
            if (at_last) begin
              state_d = SIdle;
            end else begin
              idx_d   = idx_plus1[ple_pkg::IdxW-1:0];
              state_d = SRead;
            end
          end
          ple_pkg::ACT_SEARCH: begin
            if (rd_data == val_q) begin
              res_d.status = ple_pkg::ST_OK;
              res_d.index  = ple_pkg::FidxW'(idx_q);
              res_vld_d    = 1'b1;
              state_d      = SIdle;
            end else if (at_last) begin
              res_d.status = ple_pkg::ST_MISSING;
              res_vld_d    = 1'b1;
              state_d      = SIdle;
            end else begin
              idx_d   = idx_plus1[ple_pkg::IdxW-1:0];
              state_d = SRead;
            end
          end
          default: ;
        endcase
      end

      SPut: begin
        // Place the new value into the opened slot.
        wr_en        = 1'b1;
        wr_addr      = pos_idx;
        wr_data      = val_q;
        count_d      = count_q + OneCnt;
        res_d.status = ple_pkg::ST_OK;
        res_d.count  = count_q + OneCnt;
        res_vld_d    = 1'b1;
        state_d      = SIdle;
      end

      default: state_d = SIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    act_q <= act_d;
    val_q <= val_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  assign busy            = (state_q != SIdle);
  assign result_valid_o  = res_vld_q;
  assign status_o        = res_q.status;
  assign element_value_o = res_q.value;
  assign element_valid_o = res_q.valid;
  assign found_index_o   = res_q.index;
  assign entry_count_o   = res_q.count;
  assign last_result_o   = res_q.last;

endmodule

`default_nettype wire

// ===== rtl/ple_store.sv =====
// List entry storage: one write port and one read port with registered data.
// Depends on ple_pkg for the depth and widths.
`default_nettype none

module ple_store (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [ple_pkg::IdxW-1:0]      waddr_i,
  input  wire logic signed [ple_pkg::DataW-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [ple_pkg::IdxW-1:0]      raddr_i,
  output logic signed [ple_pkg::DataW-1:0]   rdata_o
);

  logic signed [ple_pkg::DataW-1:0] mem_q [ple_pkg::Capacity];
  logic signed [ple_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
